// ===== rtl/lias_pkg.sv =====
// ----------------------------------------------------------------------------
// lias_pkg
// Shared widths, constants and sequencer states for the loop interval
// min/avg/max statistics block.
// ----------------------------------------------------------------------------
package lias_pkg;

    localparam int OFFSET_W = 10;
    localparam int STAT_W   = 16;
    localparam int SUM_W    = 32;
    localparam int MULT_W   = 20;
    localparam int SHIFT    = 18;
    localparam int PROD_W   = STAT_W + MULT_W;

    // wrap period of the offset counter, valid range 2 .. 1024 (2**OFFSET_W)
    localparam int unsigned PERIOD = 1024;

    localparam logic [MULT_W-1:0] MULT_RESET = 20'd1015762;
    localparam logic [STAT_W-1:0] MAX16      = 16'hFFFF;

    // quotient bits produced by the divider, one per cycle
    localparam int DIV_STEPS = STAT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT_WAIT,
        S_SC_LO,
        S_SC_AVG,
        S_SC_HI,
        S_SC_FIN
    } lias_state_t;

endpackage

// ===== rtl/lias_div.sv =====
// ----------------------------------------------------------------------------
// lias_div
// Restoring shift-subtract divider, one quotient bit per cycle. The
// dividend's upper half must be below the divisor, so the quotient fits
// in STAT_W bits.
// ----------------------------------------------------------------------------
module lias_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lias_pkg::SUM_W-1:0]  dividend,
    input  logic [lias_pkg::STAT_W-1:0] divisor,
    output logic                        busy,
    output logic                        done,
    output logic [lias_pkg::STAT_W-1:0] quotient
);
    import lias_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [STAT_W-1:0]   rem_reg, rem_next;
    logic [STAT_W-1:0]   quo_reg, quo_next;
    logic [STAT_W-1:0]   dsr_reg, dsr_next;

    logic [STAT_W:0]     shifted;
    logic [STAT_W:0]     diff;
    logic                ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[STAT_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        ge      = shifted >= {1'b0, dsr_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_STEPS);
            rem_next  = dividend[SUM_W-1:STAT_W];
            quo_next  = dividend[STAT_W-1:0];
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // low dividend bits shift out the top as quotient bits shift in
            rem_next  = ge ? diff[STAT_W-1:0] : shifted[STAT_W-1:0];
            quo_next  = {quo_reg[STAT_W-2:0], ge};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    a_busy_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg != '0)
        else $error("divider busy with no steps left");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done out of sequence");

endmodule

// ===== rtl/lias_scale.sv =====
// ----------------------------------------------------------------------------
// lias_scale
// Shared scaler: registered product x * mult, then >> SHIFT with
// saturation to 16 bits on the way out.
// ----------------------------------------------------------------------------
module lias_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [lias_pkg::STAT_W-1:0] operand,
    input  logic [lias_pkg::MULT_W-1:0] mult,
    output logic                        valid,
    output logic [lias_pkg::STAT_W-1:0] result
);
    import lias_pkg::*;

    logic [PROD_W-1:0]       prod_reg;
    logic                    valid_reg;
    logic [PROD_W-SHIFT-1:0] shifted;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(operand) * PROD_W'(mult);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= en;
        end
    end

    always_comb
    begin
        shifted = prod_reg[PROD_W-1:SHIFT];
        result  = (|shifted[PROD_W-SHIFT-1:STAT_W]) ? MAX16 : shifted[STAT_W-1:0];
    end

    assign valid = valid_reg;

    a_valid_follows_en: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> valid_reg)
        else $error("scaler valid lost");
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (|shifted[PROD_W-SHIFT-1:STAT_W]) |-> result == MAX16)
        else $error("scaler saturation wrong");
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !(|shifted[PROD_W-SHIFT-1:STAT_W]) |-> result == shifted[STAT_W-1:0])
        else $error("scaler passthrough wrong");

endmodule

// ===== rtl/loop_interval_min_avg_max_stats.sv =====
// ----------------------------------------------------------------------------
// loop_interval_min_avg_max_stats
// Measures intervals between loop ticks and, when the offset wraps,
// reports count and scaled min / average / max of the finished period.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  in       | in_valid / in_ready      | time_offset
//  out      | out_valid / out_ready    | sample_total, low_scaled,
//           |                          | average_scaled, high_scaled
//  cfg      | cfg_wr_en                | cfg_wr_data (scale multiplier)
//
// A tick with no wrap leaves in_ready high. A wrap tick, with in_ready low,
// runs 16 divider steps for the average (none for an empty period), waits
// for a free output register and makes three passes through the one shared
// scaler. A finished report sits in the output register while further
// ticks are accepted; the next report waits until that word is taken.
// Reset restores the multiplier and clears all statistics at once.
// ----------------------------------------------------------------------------
module loop_interval_min_avg_max_stats (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lias_pkg::OFFSET_W-1:0] time_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lias_pkg::STAT_W-1:0]   sample_total,
    output logic [lias_pkg::STAT_W-1:0]   low_scaled,
    output logic [lias_pkg::STAT_W-1:0]   average_scaled,
    output logic [lias_pkg::STAT_W-1:0]   high_scaled,
    input  logic                          cfg_wr_en,
    input  logic [lias_pkg::MULT_W-1:0]   cfg_wr_data
);
    import lias_pkg::*;

    localparam int IW = STAT_W + 2;
    localparam logic [IW-1:0] PERIOD_W = IW'(PERIOD);

    lias_state_t state_reg, state_next;

    logic [MULT_W-1:0]   mult_reg;
    logic [OFFSET_W-1:0] prev_reg;
    logic [STAT_W-1:0]   count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [STAT_W-1:0]   min_reg;
    logic [STAT_W-1:0]   max_reg;

    // snapshot of the finished period
    logic [STAT_W-1:0]   rpt_count_reg;
    logic [SUM_W-1:0]    rpt_sum_reg;
    logic [STAT_W-1:0]   rpt_min_reg;
    logic [STAT_W-1:0]   rpt_max_reg;
    logic [STAT_W-1:0]   avg_reg;

    logic                out_valid_reg;
    logic [STAT_W-1:0]   total_reg;
    logic [STAT_W-1:0]   low_reg;
    logic [STAT_W-1:0]   avg_out_reg;
    logic [STAT_W-1:0]   high_reg;

    logic                accept;
    logic                wrap;
    logic [IW-1:0]       interval_wide;
    logic [STAT_W-1:0]   interval;
    logic [STAT_W-1:0]   base_count;
    logic [SUM_W-1:0]    base_sum;
    logic [STAT_W-1:0]   base_min;
    logic [STAT_W-1:0]   base_max;

    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [STAT_W-1:0]   div_quo;

    logic                sc_en;
    logic [STAT_W-1:0]   sc_operand;
    logic                sc_valid;
    logic [STAT_W-1:0]   sc_result;

    assign accept = in_valid && in_ready;
    assign wrap   = time_offset < prev_reg;

    always_comb
    begin
        if (wrap)
        begin
            interval_wide = IW'(time_offset) + PERIOD_W - IW'(prev_reg);
        end
        else
        begin
            interval_wide = IW'(time_offset) - IW'(prev_reg);
        end
        interval   = interval_wide[STAT_W-1:0];
        base_count = wrap ? '0 : count_reg;
        base_sum   = wrap ? '0 : sum_reg;
        base_min   = wrap ? MAX16 : min_reg;
        base_max   = wrap ? '0 : max_reg;
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (accept && wrap) state_next = S_DIV_START;
            S_DIV_START: state_next = (rpt_count_reg == '0) ? S_OUT_WAIT : S_DIV_WAIT;
            S_DIV_WAIT:  if (div_done) state_next = S_OUT_WAIT;
            S_OUT_WAIT:  if (!out_valid_reg) state_next = S_SC_LO;
            S_SC_LO:     state_next = S_SC_AVG;
            S_SC_AVG:    state_next = S_SC_HI;
            S_SC_HI:     state_next = S_SC_FIN;
            S_SC_FIN:    state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        div_start  = 1'b0;
        sc_en      = 1'b0;
        sc_operand = rpt_min_reg;
        unique case (state_reg)
            S_IDLE:      in_ready = 1'b1;
            S_DIV_START: div_start = rpt_count_reg != '0;
            S_SC_LO:
            begin
                sc_en      = 1'b1;
                sc_operand = rpt_min_reg;
            end
            S_SC_AVG:
            begin
                sc_en      = 1'b1;
                sc_operand = avg_reg;
            end
            S_SC_HI:
            begin
                sc_en      = 1'b1;
                sc_operand = rpt_max_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // -------------------------------------------------------------- statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mult_reg  <= MULT_RESET;
            prev_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= MAX16;
            max_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                mult_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                prev_reg <= time_offset;
                if (base_count != MAX16)
                begin
                    count_reg <= base_count + STAT_W'(1);
                    sum_reg   <= base_sum + SUM_W'(interval);
                end
                else
                begin
                    count_reg <= base_count;
                    sum_reg   <= base_sum;
                end
                min_reg <= (interval < base_min) ? interval : base_min;
                max_reg <= (interval > base_max) ? interval : base_max;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wrap)
        begin
            rpt_count_reg <= count_reg;
            rpt_sum_reg   <= sum_reg;
            rpt_min_reg   <= min_reg;
            rpt_max_reg   <= max_reg;
        end
        if (state_reg == S_DIV_START)
        begin
            avg_reg <= '0;
        end
        else if (state_reg == S_DIV_WAIT && div_done)
        begin
            avg_reg <= div_quo;
        end
    end

    // ------------------------------------------------------------ output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_SC_FIN)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // scaler results land in the state after the one that issued their operand
    always_ff @(posedge clk)
    begin
        if (sc_valid)
        begin
            case (state_reg)
                S_SC_AVG: low_reg     <= sc_result;
                S_SC_HI:  avg_out_reg <= sc_result;
                S_SC_FIN: high_reg    <= sc_result;
                default:  high_reg    <= high_reg;
            endcase
        end
        if (state_reg == S_SC_LO)
        begin
            total_reg <= rpt_count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sample_total   = total_reg;
    assign low_scaled     = low_reg;
    assign average_scaled = avg_out_reg;
    assign high_scaled    = high_reg;

    lias_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rpt_sum_reg),
        .divisor  (rpt_count_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    lias_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (sc_en),
        .operand (sc_operand),
        .mult    (mult_reg),
        .valid   (sc_valid),
        .result  (sc_result)
    );

    a_wrap_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && wrap |=> !in_ready)
        else $error("wrap tick did not start a report");
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> sum_reg[SUM_W-1:STAT_W] < count_reg)
        else $error("interval sum out of range for count");
    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> sum_reg == '0)
        else $error("sum nonzero with zero count");
    a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == S_DIV_WAIT)
        else $error("divider running outside its wait state");
    a_scale_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SC_LO |-> !out_valid_reg)
        else $error("report scaled over an untaken word");

endmodule
